// ===== rtl/core/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared widths, default sensor count, register reset values, register
// indexes and divide-by-ten constants for the line tracking steering block.
// ----------------------------------------------------------------------------
package lts_pkg;

	// default number of line sensors
	localparam int SENSOR_COUNT_DEF = 12;

	// register and result widths
	localparam int GAIN_W     = 12;
	localparam int SPEED_W    = 14;
	localparam int OUT_W      = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// register reset values (gain Q4.8, speeds Q6.8)
	localparam logic [GAIN_W-1:0]  GAIN_RST     = 12'd374;
	localparam logic [SPEED_W-1:0] BASE_RST     = 14'd2944;
	localparam logic [SPEED_W-1:0] MAX_CORR_RST = 14'd4352;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CORRECTION = 2'd2;

	// floor(x/10) = (x * DIV10_MUL) >> DIV10_SHIFT, exact for 16-bit x
	localparam logic [15:0] DIV10_MUL   = 16'd52429;
	localparam int          DIV10_SHIFT = 19;

endpackage

// ===== rtl/core/line_track_steering.sv =====
// ----------------------------------------------------------------------------
// line_track_steering
// Proportional line-following steering: sensor snapshot in, wheel target
// speeds and a line-lost flag out.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_stall  | sensor_bits
//  output   | out_valid / out_stall| left_target, right_target, line_lost
//  config   | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle is sustained while out_stall is low. The sensor
// offset is summed and registered on input, then gain multiply, clamps and
// wheel sums run into the result register. The pipeline advances whenever
// the result register is empty or taken; out_stall backs up into in_stall.
// Reset clears valid flags, the offset history and loads register defaults.
// ----------------------------------------------------------------------------
module line_track_steering #(
	parameter int SENSOR_COUNT = lts_pkg::SENSOR_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_we,
	input  logic [lts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lts_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [SENSOR_COUNT-1:0]        sensor_bits,

	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lts_pkg::OUT_W-1:0]      left_target,
	output logic [lts_pkg::OUT_W-1:0]      right_target,
	output logic                           line_lost
);

	// offset magnitude is at most about SENSOR_COUNT^2/4 half-sensor steps
	localparam int OFS_W = $clog2((SENSOR_COUNT * SENSOR_COUNT) / 4 + 1) + 1;
	localparam int P_W   = lts_pkg::GAIN_W + 1 + OFS_W;
	localparam int O_W   = lts_pkg::OUT_W;
	localparam int S_W   = lts_pkg::OUT_W + 3;

	// configuration registers
	logic [lts_pkg::GAIN_W-1:0]  gain_q;
	logic [lts_pkg::SPEED_W-1:0] base_q;
	logic [lts_pkg::SPEED_W-1:0] max_corr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q     <= lts_pkg::GAIN_RST;
			base_q     <= lts_pkg::BASE_RST;
			max_corr_q <= lts_pkg::MAX_CORR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lts_pkg::CFG_STEER_GAIN:     gain_q     <= cfg_data[lts_pkg::GAIN_W-1:0];
				lts_pkg::CFG_BASE_SPEED:     base_q     <= cfg_data[lts_pkg::SPEED_W-1:0];
				lts_pkg::CFG_MAX_CORRECTION: max_corr_q <= cfg_data[lts_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake control
	logic valid_s1;
	logic advance;
	logic in_take;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// weighted sensor sum: sensor i counts 2i-(N-1)
	logic signed [OFS_W-1:0] ofs_sum;
	logic                    any_set;

	always_comb begin
		logic signed [OFS_W-1:0] w;
		ofs_sum = '0;
		any_set = |sensor_bits;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			w = OFS_W'(2 * i - (SENSOR_COUNT - 1));
			if (sensor_bits[i]) begin
				ofs_sum = ofs_sum + w;
			end
		end
	end

	// input stage
	logic signed [OFS_W-1:0] ofs_s1;
	logic                    lost_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ofs_s1  <= ofs_sum;
			lost_s1 <= !any_set;
		end
	end

	// offset history, kept from the last transaction that saw the line
	logic signed [OFS_W-1:0] last_ofs_q;
	logic signed [OFS_W-1:0] ofs_sel;

	assign ofs_sel = lost_s1 ? last_ofs_q : ofs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_ofs_q <= '0;
		end else if (valid_s1 && advance && !lost_s1) begin
			last_ofs_q <= ofs_s1;
		end
	end

	// correction: gain*offset/2, rounded half away from zero, clamped
	logic signed [P_W-1:0] prod;
	logic                  prod_neg;
	logic [P_W-1:0]        prod_mag;
	logic [P_W-1:0]        corr_mag;
	logic [O_W-1:0]        corr_lim;
	logic [O_W-1:0]        corr_cl;

	always_comb begin
		prod     = P_W'($signed({1'b0, gain_q})) * P_W'(ofs_sel);
		prod_neg = prod[P_W-1];
		prod_mag = prod_neg ? P_W'(-prod) : P_W'(prod);
		corr_mag = (prod_mag + P_W'(1)) >> 1;
		corr_lim = lost_s1 ? {max_corr_q, 1'b0} : O_W'(max_corr_q);
		corr_cl  = (corr_mag > P_W'(corr_lim)) ? corr_lim : corr_mag[O_W-1:0];
	end

	// speed bounds
	logic [15:0]    base_x3;
	logic [31:0]    div10_prod;
	logic [O_W-1:0] lo_bound;
	logic [O_W-1:0] hi_bound;

	always_comb begin
		base_x3    = 16'(base_q) * 16'd3;
		div10_prod = 32'(base_x3) * 32'(lts_pkg::DIV10_MUL);
		if (lost_s1) begin
			lo_bound = O_W'(div10_prod >> lts_pkg::DIV10_SHIFT);
			hi_bound = {base_q, 1'b0};
		end else begin
			lo_bound = O_W'(base_q >> 1);
			hi_bound = base_x3[O_W:1];
		end
	end

	// wheel sums and clamps
	logic signed [S_W-1:0] base_e;
	logic signed [S_W-1:0] corr_s;
	logic signed [S_W-1:0] lo_e;
	logic signed [S_W-1:0] hi_e;
	logic signed [S_W-1:0] left_raw;
	logic signed [S_W-1:0] right_raw;
	logic [O_W-1:0]        left_cl;
	logic [O_W-1:0]        right_cl;

	always_comb begin
		base_e    = S_W'(base_q);
		corr_s    = prod_neg ? -S_W'(corr_cl) : S_W'(corr_cl);
		lo_e      = S_W'(lo_bound);
		hi_e      = S_W'(hi_bound);
		left_raw  = base_e + corr_s;
		right_raw = base_e - corr_s;

		if (left_raw < lo_e) begin
			left_cl = lo_bound;
		end else if (left_raw > hi_e) begin
			left_cl = hi_bound;
		end else begin
			left_cl = left_raw[O_W-1:0];
		end

		if (right_raw < lo_e) begin
			right_cl = lo_bound;
		end else if (right_raw > hi_e) begin
			right_cl = hi_bound;
		end else begin
			right_cl = right_raw[O_W-1:0];
		end
	end

	// result register
	logic           out_valid_q;
	logic [O_W-1:0] left_q;
	logic [O_W-1:0] right_q;
	logic           lost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			left_q  <= left_cl;
			right_q <= right_cl;
			lost_q  <= lost_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign left_target  = left_q;
	assign right_target = right_q;
	assign line_lost    = lost_q;

endmodule
